/* rtl/heq_pkg.sv */
// shared types and constants for the explicit heat equation stepper
`timescale 1ns / 1ps
`default_nettype none

package heq_pkg;

    localparam int IDX_W      = 6;
    localparam int IN_W       = 24;
    localparam int K_W        = 16;
    localparam int GS_W       = 7;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BND   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BND  = 2'd3;

    localparam logic [K_W-1:0]  RST_DIFF_COEF = 16'd6554;
    localparam logic [GS_W-1:0] RST_GRID_SIZE = 7'd11;
    localparam logic [IN_W-1:0] RST_LEFT_BND  = 24'd0;
    localparam logic [IN_W-1:0] RST_RIGHT_BND = 24'd65536;

    localparam logic [K_W-1:0]  K_MAX    = 16'd32768;
    localparam logic [K_W:0]    K_ONE    = 17'd65536;
    localparam logic [GS_W-1:0] GRID_MIN = 7'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic            load_we;
        logic            issue;
        logic            rd;
        logic            first;
        logic            left;
        logic            right;
        logic [GS_W-1:0] slot;
    } ctrl_cmd_t;

    typedef struct packed {
        logic adv;
        logic idle;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/heq_ctrl.sv */
// sequencer: accepts requests and walks the sweep slots of a step
`timescale 1ns / 1ps
`default_nettype none

module heq_ctrl #(
    parameter int GRID_POINTS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic                     command,
    input  wire logic [heq_pkg::GS_W-1:0] grid_size,
    input  wire heq_pkg::dp_status_t      status,
    output heq_pkg::ctrl_cmd_t            cmd
);
    import heq_pkg::*;

    state_t          state_reg, state_next;
    logic [GS_W-1:0] cnt_reg, cnt_next;
    logic [GS_W-1:0] n_pts;

    // grid size clamped to the usable range
    always_comb
    begin
        if (grid_size < GRID_MIN)
            n_pts = GRID_MIN;
        else if (grid_size > GS_W'(GRID_POINTS))
            n_pts = GS_W'(GRID_POINTS);
        else
            n_pts = grid_size;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.load_we = 1'b0;
        cmd.issue   = 1'b0;
        cmd.rd      = (cnt_reg < n_pts);
        cmd.first   = (cnt_reg == '0);
        cmd.left    = (cnt_reg == GS_W'(1));
        cmd.right   = (cnt_reg == n_pts);
        cmd.slot    = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (command == CMD_STEP)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (status.adv)
                begin
                    cmd.issue = 1'b1;
                    if (cnt_reg == n_pts)
                        state_next = ST_DRAIN;
                    else
                        cnt_next = cnt_reg + GS_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (status.idle)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/heq_datapath.sv */
// row store, three point stencil pipeline and output register
`timescale 1ns / 1ps
`default_nettype none

module heq_datapath #(
    parameter int GRID_POINTS = 64,
    parameter int VALUE_BITS  = 24
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire heq_pkg::ctrl_cmd_t        cmd,
    output heq_pkg::dp_status_t            status,
    input  wire logic [heq_pkg::K_W-1:0]   diffusion_coefficient,
    input  wire logic [heq_pkg::IN_W-1:0]  left_boundary,
    input  wire logic [heq_pkg::IN_W-1:0]  right_boundary,
    input  wire logic [heq_pkg::IDX_W-1:0] point_index,
    input  wire logic [heq_pkg::IN_W-1:0]  sample_value,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic [heq_pkg::IDX_W-1:0]      result_index,
    output logic [VALUE_BITS-1:0]          result_value,
    output logic                           row_last
);
    import heq_pkg::*;

    localparam int AW    = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
    localparam int EW    = (VALUE_BITS > IN_W) ? VALUE_BITS : IN_W;
    localparam int PW    = VALUE_BITS + 18;
    localparam int ACW   = VALUE_BITS + 19;
    localparam int RW    = VALUE_BITS + 3;
    localparam logic signed [EW-1:0] IN_HI = EW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] IN_LO = -IN_HI - EW'(1);
    localparam logic signed [RW-1:0] R_HI  = RW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] R_LO  = -R_HI - RW'(1);
    localparam logic signed [ACW-1:0] HALF = ACW'(32768);

    // 24 bit field sign extended and clipped to the stored width
    function automatic logic [VALUE_BITS-1:0] fit_in(input logic [IN_W-1:0] v);
        logic signed [EW-1:0] x;
        x = EW'(signed'(v));
        if (x > IN_HI)
            return VALUE_BITS'(IN_HI);
        else if (x < IN_LO)
            return VALUE_BITS'(IN_LO);
        else
            return VALUE_BITS'(x);
    endfunction

    logic [VALUE_BITS-1:0]   mem [GRID_POINTS];
    logic [GRID_POINTS-1:0]  vld_reg;
    logic [VALUE_BITS-1:0]   rd_reg;
    logic                    rd_vld_reg;

    logic                    en;
    logic                    s1_vld_reg, s1_first_reg, s1_left_reg, s1_right_reg;
    logic [IDX_W-1:0]        s1_pt_reg;
    logic signed [VALUE_BITS-1:0] prev_reg, cur_reg;
    logic signed [VALUE_BITS-1:0] rd_val;

    logic                    s2_vld_reg, s2_bnd_reg, s2_last_reg;
    logic [IDX_W-1:0]        s2_pt_reg;
    logic [VALUE_BITS-1:0]   s2_bval_reg;
    logic signed [PW-1:0]    p1_reg, p2_reg;

    logic                    out_vld_reg, out_last_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [VALUE_BITS-1:0]   out_val_reg;

    logic [K_W-1:0]          k_eff;
    logic [K_W:0]            k2;
    logic signed [VALUE_BITS:0] nsum;
    logic signed [PW-1:0]    p1_next, p2_next;
    logic signed [ACW-1:0]   acc;
    logic signed [RW-1:0]    rnd;
    logic [VALUE_BITS-1:0]   new_val;

    logic                    ld_ok;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [VALUE_BITS-1:0]   wr_data;

    assign en          = !out_vld_reg || out_ready;
    assign status.adv  = en;
    assign status.idle = !s1_vld_reg && !s2_vld_reg && !out_vld_reg;

    // coefficient clamped to one half for stability
    assign k_eff  = (diffusion_coefficient > K_MAX) ? K_MAX : diffusion_coefficient;
    assign k2     = K_ONE - {k_eff, 1'b0};
    assign rd_val = rd_vld_reg ? signed'(rd_reg) : '0;

    assign nsum    = (VALUE_BITS + 1)'(prev_reg) + (VALUE_BITS + 1)'(rd_val);
    assign p1_next = PW'(nsum * signed'({1'b0, k_eff}));
    assign p2_next = PW'(cur_reg * signed'({1'b0, k2}));

    // round half up from Q.16 to the sample scale then clip
    assign acc = ACW'(p1_reg) + ACW'(p2_reg) + HALF;
    assign rnd = acc[ACW-1:16];
    always_comb
    begin
        if (rnd > R_HI)
            new_val = VALUE_BITS'(R_HI);
        else if (rnd < R_LO)
            new_val = VALUE_BITS'(R_LO);
        else
            new_val = VALUE_BITS'(rnd);
    end

    // one write port shared by loads and the sweep write-back
    assign ld_ok = ({1'b0, point_index} < (IDX_W + 1)'(GRID_POINTS));
    always_comb
    begin
        if (cmd.load_we)
        begin
            wr_en   = ld_ok;
            wr_addr = point_index[AW-1:0];
            wr_data = fit_in(sample_value);
        end
        else
        begin
            wr_en   = en && s2_vld_reg;
            wr_addr = s2_pt_reg[AW-1:0];
            wr_data = s2_bnd_reg ? s2_bval_reg : new_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (en && cmd.issue && cmd.rd)
            rd_reg <= mem[cmd.slot[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            if (en && cmd.issue && cmd.rd)
                rd_vld_reg <= vld_reg[cmd.slot[AW-1:0]];
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= cmd.issue;
            s2_vld_reg  <= s1_vld_reg && !s1_first_reg;
            out_vld_reg <= s2_vld_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_first_reg <= cmd.first;
            s1_left_reg  <= cmd.left;
            s1_right_reg <= cmd.right;
            s1_pt_reg    <= IDX_W'(cmd.slot - GS_W'(1));
            if (s1_vld_reg)
            begin
                prev_reg <= cur_reg;
                cur_reg  <= rd_val;
            end
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            s2_bnd_reg  <= s1_left_reg || s1_right_reg;
            s2_bval_reg <= s1_left_reg ? fit_in(left_boundary) : fit_in(right_boundary);
            s2_last_reg <= s1_right_reg;
            s2_pt_reg   <= s1_pt_reg;
            out_val_reg  <= s2_bnd_reg ? s2_bval_reg : new_val;
            out_idx_reg  <= s2_pt_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid    = out_vld_reg;
    assign result_index = out_idx_reg;
    assign result_value = out_val_reg;
    assign row_last     = out_last_reg;

endmodule

`default_nettype wire

/* rtl/heat_equation_explicit_step.sv */
// top level of the explicit heat equation stepper
//
// usage: the slave stream carries requests. tuser is the command: a load
// writes sample_value at point_index into the row store and gives no
// result; a step advances the row by one explicit time step and sends the
// whole new row on the master stream, one sample per point, point 0 first,
// tlast on the last point of the grid.
// a step reads the row store once per point over a single read port, and
// the next request is taken only once the last sample has been taken and
// the pipeline has drained; a load is taken in the idle state.
// the end points are forced to the boundary registers, the interior points
// are saturated to the value width.
// configuration is written through cfg_we/cfg_index/cfg_data while idle.
// reset clears the row store to zero (valid bits per point) and loads the
// register defaults; no clearing pass is needed.
// a stall on m_axis_tready freezes the whole sweep; nothing is lost, and
// s_axis_tready stays low until the last sample has been taken.
`timescale 1ns / 1ps
`default_nettype none

module heat_equation_explicit_step #(
    parameter int GRID_POINTS = 64,
    parameter int VALUE_BITS  = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // point_index [5:0], sample_value [29:6], zero fill above
    input  wire logic [heq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command [0]
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // result_index [5:0], result_value [VALUE_BITS+5:6], zero fill above
    output logic [((heq_pkg::IDX_W + VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // row_last
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [heq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [heq_pkg::CFG_W-1:0]       cfg_data
);
    import heq_pkg::*;

    localparam int OUT_W = ((IDX_W + VALUE_BITS + 7) / 8) * 8;

    logic [K_W-1:0]  diff_coef_reg;
    logic [GS_W-1:0] grid_size_reg;
    logic [IN_W-1:0] left_bnd_reg;
    logic [IN_W-1:0] right_bnd_reg;

    ctrl_cmd_t             cmd;
    dp_status_t            status;
    logic [IDX_W-1:0]      result_index;
    logic [VALUE_BITS-1:0] result_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_coef_reg <= RST_DIFF_COEF;
            grid_size_reg <= RST_GRID_SIZE;
            left_bnd_reg  <= RST_LEFT_BND;
            right_bnd_reg <= RST_RIGHT_BND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIFF_COEF: diff_coef_reg <= cfg_data[K_W-1:0];
                CFG_GRID_SIZE: grid_size_reg <= cfg_data[GS_W-1:0];
                CFG_LEFT_BND:  left_bnd_reg  <= cfg_data[IN_W-1:0];
                CFG_RIGHT_BND: right_bnd_reg <= cfg_data[IN_W-1:0];
                default: ;
            endcase
        end
    end

    heq_ctrl #(
        .GRID_POINTS (GRID_POINTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .command       (s_axis_tuser),
        .grid_size     (grid_size_reg),
        .status        (status),
        .cmd           (cmd)
    );

    heq_datapath #(
        .GRID_POINTS (GRID_POINTS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .status                (status),
        .diffusion_coefficient (diff_coef_reg),
        .left_boundary         (left_bnd_reg),
        .right_boundary        (right_bnd_reg),
        .point_index           (s_axis_tdata[IDX_W-1:0]),
        .sample_value          (s_axis_tdata[IDX_W+IN_W-1:IDX_W]),
        .out_ready             (m_axis_tready),
        .out_valid             (m_axis_tvalid),
        .result_index          (result_index),
        .result_value          (result_value),
        .row_last              (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({result_value, result_index});

endmodule

`default_nettype wire

/* rtl/heq_checker.sv */
// port level checks for the heat equation stepper, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module heq_checker #(
    parameter int VALUE_BITS = 24
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic s_axis_tuser,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [((heq_pkg::IDX_W + VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input wire logic m_axis_tlast
);
    import heq_pkg::*;

    // a stalled sample holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // no request taken while a sample is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request ready while row output pending");

    // a step request blocks further requests
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_STEP) |=> !s_axis_tready)
        else $error("ready straight after a step request");

    // the row ends at tlast
    a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("sample after end of row");

endmodule

bind heat_equation_explicit_step heq_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_heq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the explicit heat equation stepper
`timescale 1ns / 1ps

module tb;

    import heq_pkg::*;

    localparam int M_W         = ((IDX_W + 24 + 7) / 8) * 8;
    localparam int ROW_MAX     = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_STEP,
        ROW_CFG
    } plan_kind_t;

    // one line of the directed table; pin_* types in one sample of a step
    typedef struct packed {
        plan_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_i;
        logic [IDX_W-1:0]     idx;
        logic [CFG_W-1:0]     val;
        logic                 pinned;
        logic [IDX_W-1:0]     pin_i;
        logic [IN_W-1:0]      pin_v;
    } plan_row_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [IN_W-1:0]  val;
        logic             last;
    } sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic                  s_tuser = CMD_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_W-1:0]        m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DIFF_COEF;
    logic [CFG_W-1:0]      cfg_data = '0;

    // predictor copy of the registers and the row store
    logic [K_W-1:0]         coef_q;
    logic [GS_W-1:0]        size_q;
    logic signed [IN_W-1:0] left_q;
    logic signed [IN_W-1:0] right_q;
    logic signed [IN_W-1:0] row_mem [ROW_MAX];

    sample_t row_expect [$];
    plan_row_t plan [25];

    int miss_cnt = 0;
    int checked_cnt = 0;
    int load_cnt = 0;
    int step_cnt = 0;
    int setting_cnt = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    heat_equation_explicit_step dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_cnt);
            $display("tb: errors");
            $finish;
        end
    end

    task automatic note_miss(input string msg);
        $display("tb: mismatch: %s", msg);
        miss_cnt++;
    endtask

    function automatic int eff_size();
        if (size_q < GRID_MIN)
            return int'(GRID_MIN);
        if (int'(size_q) > ROW_MAX)
            return ROW_MAX;
        return int'(size_q);
    endfunction

    // one explicit time step on the predictor row, queuing the new row
    task automatic advance_row(input logic pinned, input int pin_i, input logic [IN_W-1:0] pin_v);
        longint kk, k2, prev, cur, acc, r;
        int n;
        sample_t s;
        kk = (coef_q > K_MAX) ? longint'(K_MAX) : longint'(coef_q);
        k2 = longint'(K_ONE) - 2 * kk;
        n = eff_size();
        prev = row_mem[0];
        for (int i = 1; i < n - 1; i++)
        begin
            cur = row_mem[i];
            acc = kk * (prev + longint'(row_mem[i + 1])) + k2 * cur;
            // floor after adding one half gives round half up
            r = (acc + 32768) >>> 16;
            if (r > 64'sd8388607)
                r = 64'sd8388607;
            else if (r < -64'sd8388608)
                r = -64'sd8388608;
            row_mem[i] = r[IN_W-1:0];
            prev = cur;
        end
        row_mem[0] = left_q;
        row_mem[n - 1] = right_q;
        for (int i = 0; i < n; i++)
        begin
            s.idx = i[IDX_W-1:0];
            s.val = (pinned && i == pin_i) ? pin_v : row_mem[i];
            s.last = (i == n - 1);
            row_expect.push_back(s);
        end
    endtask

    // offer one request, optionally after an idle gap, and predict on acceptance
    task automatic push_request(input logic cmd, input logic [IDX_W-1:0] idx,
                                input logic [IN_W-1:0] val, input logic pinned,
                                input int pin_i, input logic [IN_W-1:0] pin_v);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && gap < 8 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, val, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cmd == CMD_LOAD)
        begin
            row_mem[idx] = val;
            load_cnt++;
        end
        else
        begin
            advance_row(pinned, pin_i, pin_v);
            step_cnt++;
        end
    endtask

    // wait until the row has drained and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (row_expect.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= ri;
        cfg_data <= v;
        case (ri)
            CFG_DIFF_COEF: coef_q = v[K_W-1:0];
            CFG_GRID_SIZE: size_q = v[GS_W-1:0];
            CFG_LEFT_BND:  left_q = v;
            CFG_RIGHT_BND: right_q = v;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($signed($urandom_range(524288)) - 262144);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic pick_setting();
        logic [CFG_W-1:0] k, g;
        case ($urandom_range(9))
            0: k = '0;
            1: k = CFG_W'(32768);
            2: k = CFG_W'($urandom_range(65535, 32769));
            3: k = 24'hFFFFFF;
            default: k = CFG_W'($urandom_range(32768));
        endcase
        case ($urandom_range(19))
            0: g = CFG_W'($urandom_range(2));
            1: g = CFG_W'($urandom_range(127, 65));
            2: g = CFG_W'(64);
            3: g = CFG_W'($urandom_range(63, 13));
            default: g = CFG_W'($urandom_range(12, 3));
        endcase
        settle();
        set_reg(CFG_DIFF_COEF, k);
        set_reg(CFG_GRID_SIZE, g);
        set_reg(CFG_LEFT_BND, rand_sample());
        set_reg(CFG_RIGHT_BND, rand_sample());
        setting_cnt++;
    endtask

    // mostly loads across the live grid followed by a few steps, some noise
    task automatic run_mix(input int quota);
        int made, n, m, steps;
        made = 0;
        while (made < quota)
        begin
            n = eff_size();
            if ($urandom_range(9) < 8)
            begin
                m = $urandom_range((n < 6) ? n : 6, 1);
                steps = $urandom_range(3, 1);
                repeat (m)
                    push_request(CMD_LOAD, IDX_W'($urandom_range(n - 1)), rand_sample(),
                                 1'b0, 0, '0);
                repeat (steps)
                    push_request(CMD_STEP, 6'($urandom()), 24'($urandom()), 1'b0, 0, '0);
                made += m + steps;
            end
            else
            begin
                if ($urandom_range(1) == 0)
                    push_request(CMD_LOAD, 6'($urandom()), rand_sample(), 1'b0, 0, '0);
                else
                    push_request(CMD_STEP, 6'($urandom()), 24'($urandom()), 1'b0, 0, '0);
                made++;
            end
        end
    endtask

    // receiver: checks every sample taken and drives tready
    always @(posedge clk)
    begin : sink
        sample_t want;
        logic [IDX_W-1:0] got_idx;
        logic [IN_W-1:0] got_val;
        got_idx = m_axis_tdata[IDX_W-1:0];
        got_val = m_axis_tdata[IDX_W+IN_W-1:IDX_W];
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            if (row_expect.size() == 0)
                note_miss($sformatf("sample at point %0d with nothing pending", got_idx));
            else
            begin
                want = row_expect.pop_front();
                checked_cnt++;
                if (got_idx != want.idx)
                    note_miss($sformatf("index %0d, wanted %0d", got_idx, want.idx));
                if (got_val != want.val)
                    note_miss($sformatf("point %0d value %h, wanted %h",
                                        want.idx, got_val, want.val));
                if (m_axis_tlast != want.last)
                    note_miss($sformatf("point %0d tlast %b, wanted %b",
                                        want.idx, m_axis_tlast, want.last));
            end
        end
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        coef_q = RST_DIFF_COEF;
        size_q = RST_GRID_SIZE;
        left_q = RST_LEFT_BND;
        right_q = RST_RIGHT_BND;
        for (int i = 0; i < ROW_MAX; i++)
            row_mem[i] = '0;

        //                kind      reg            idx    val           pin   at     value
        plan[0]  = '{ROW_STEP, CFG_DIFF_COEF, 6'd0,  24'h000000, 1'b1, 6'd10, 24'h010000};
        plan[1]  = '{ROW_CFG,  CFG_GRID_SIZE, 6'd0,  24'd3,      1'b0, 6'd0,  24'h000000};
        plan[2]  = '{ROW_CFG,  CFG_DIFF_COEF, 6'd0,  24'hFFFFFF, 1'b0, 6'd0,  24'h000000};
        plan[3]  = '{ROW_LOAD, CFG_DIFF_COEF, 6'd0,  24'h800000, 1'b0, 6'd0,  24'h000000};
        plan[4]  = '{ROW_LOAD, CFG_DIFF_COEF, 6'd2,  24'h800000, 1'b0, 6'd0,  24'h000000};
        plan[5]  = '{ROW_LOAD, CFG_DIFF_COEF, 6'd1,  24'h7FFFFF, 1'b0, 6'd0,  24'h000000};
        // coefficient clamped to one half: middle point is the mean of its neighbours
        plan[6]  = '{ROW_STEP, CFG_DIFF_COEF, 6'd0,  24'h000000, 1'b1, 6'd1,  24'h800000};
        plan[7]  = '{ROW_CFG,  CFG_LEFT_BND,  6'd0,  24'h800000, 1'b0, 6'd0,  24'h000000};
        plan[8]  = '{ROW_CFG,  CFG_RIGHT_BND, 6'd0,  24'h7FFFFF, 1'b0, 6'd0,  24'h000000};
        // grid size below the minimum counts as three points
        plan[9]  = '{ROW_CFG,  CFG_GRID_SIZE, 6'd0,  24'd0,      1'b0, 6'd0,  24'h000000};
        plan[10] = '{ROW_STEP, CFG_DIFF_COEF, 6'd0,  24'h000000, 1'b1, 6'd2,  24'h7FFFFF};
        plan[11] = '{ROW_CFG,  CFG_DIFF_COEF, 6'd0,  24'd0,      1'b0, 6'd0,  24'h000000};
        // loads beyond the live grid still land in the store
        plan[12] = '{ROW_LOAD, CFG_DIFF_COEF, 6'd63, 24'h7FFFFF, 1'b0, 6'd0,  24'h000000};
        plan[13] = '{ROW_LOAD, CFG_DIFF_COEF, 6'd40, 24'd12345,  1'b0, 6'd0,  24'h000000};
        plan[14] = '{ROW_CFG,  CFG_GRID_SIZE, 6'd0,  24'hFFFFFF, 1'b0, 6'd0,  24'h000000};
        // zero coefficient leaves the interior untouched
        plan[15] = '{ROW_STEP, CFG_DIFF_COEF, 6'd0,  24'h000000, 1'b1, 6'd40, 24'd12345};
        plan[16] = '{ROW_CFG,  CFG_DIFF_COEF, 6'd0,  24'd32768,  1'b0, 6'd0,  24'h000000};
        plan[17] = '{ROW_CFG,  CFG_GRID_SIZE, 6'd0,  24'd64,     1'b0, 6'd0,  24'h000000};
        plan[18] = '{ROW_STEP, CFG_DIFF_COEF, 6'd63, 24'hFFFFFF, 1'b0, 6'd0,  24'h000000};
        plan[19] = '{ROW_CFG,  CFG_DIFF_COEF, 6'd0,  24'd6554,   1'b0, 6'd0,  24'h000000};
        plan[20] = '{ROW_CFG,  CFG_GRID_SIZE, 6'd0,  24'd5,      1'b0, 6'd0,  24'h000000};
        plan[21] = '{ROW_LOAD, CFG_DIFF_COEF, 6'd2,  24'h000064, 1'b0, 6'd0,  24'h000000};
        plan[22] = '{ROW_LOAD, CFG_DIFF_COEF, 6'd3,  24'hFFFFFF, 1'b0, 6'd0,  24'h000000};
        plan[23] = '{ROW_STEP, CFG_DIFF_COEF, 6'd0,  24'h000000, 1'b0, 6'd0,  24'h000000};
        plan[24] = '{ROW_STEP, CFG_DIFF_COEF, 6'd0,  24'h000000, 1'b0, 6'd0,  24'h000000};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_CFG:
                begin
                    settle();
                    set_reg(plan[i].reg_i, plan[i].val);
                    setting_cnt++;
                end
                ROW_LOAD: push_request(CMD_LOAD, plan[i].idx, plan[i].val, 1'b0, 0, '0);
                default:  push_request(CMD_STEP, plan[i].idx, plan[i].val, plan[i].pinned,
                                       int'(plan[i].pin_i), plan[i].pin_v);
            endcase
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int sub = 0; sub < 2; sub++)
            begin
                pick_setting();
                if (ph == 2 && sub == 0)
                begin
                    // long receiver hold while steps keep coming, so the block backs up
                    hold_asks <= hold_asks + 1;
                    repeat (4)
                        push_request(CMD_STEP, 6'($urandom()), 24'($urandom()), 1'b0, 0, '0);
                end
                run_mix(38);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (row_expect.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("tb: %0d requests taken (%0d loads, %0d steps) under %0d register settings",
                 load_cnt + step_cnt, load_cnt, step_cnt, setting_cnt);
        $display("tb: %0d row samples compared across four idling mixes and one long hold",
                 checked_cnt);
        if (miss_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
